// ----- design/prefixed_number_token_parser_top_macros.svh -----
// Assertion macros for the prefixed number token parser.
// Included by the top level; depends on i_clk and i_rst_n in the including scope.
`ifndef PREFIXED_NUMBER_TOKEN_PARSER_TOP_MACROS_SVH
`define PREFIXED_NUMBER_TOKEN_PARSER_TOP_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define PNTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define PNTP_NEVER(lbl, cond, msg) \
    `PNTP_ASSERT(lbl, !(cond), msg)

`endif

// ----- design/pntp_pkg.sv -----
// Shared types, constants and helper functions for the prefixed number token parser.
// Used by the top level, pntp_step and pntp_result; depends on nothing.
package pntp_pkg;

    localparam int RESULT_WIDTH_DEF = 32;
    localparam int ACCUM_WIDTH_DEF  = 64;
    localparam int MAX_WIDTH        = 64;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEFAULT_BASE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OVERFLOW_SAT = 1'b1;
    localparam int CFG_DATA_WIDTH = 6;

    localparam logic [5:0] BASE_RESET     = 6'd10;
    localparam logic [5:0] BASE_MIN       = 6'd2;
    localparam logic [5:0] BASE_MAX       = 6'd36;
    localparam logic [5:0] BASE_HEX_LIMIT = 6'd33;
    localparam logic [5:0] BASE_DEC       = 6'd10;
    localparam logic [5:0] BASE_BIN       = 6'd2;
    localparam logic [5:0] BASE_HEX       = 6'd16;

    // Parse phases of the word grammar.
    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_QCHAR  = 3'd4;
    localparam logic [2:0] PH_QCLOSE = 3'd5;
    localparam logic [2:0] PH_QDONE  = 3'd6;

    localparam logic [2:0] POS_MAX = 3'd7;

    // Character codes with a meaning in the grammar.
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;

    // Word state apart from the accumulator.
    typedef struct packed {
        logic [2:0] pos;
        logic [2:0] phase;
        logic       minus;
        logic [5:0] base;
        logic       ovf;
        logic       digit_seen;
        logic       invalid;
        logic [7:0] qchar;
    } t_ctrl;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_digit;

    localparam t_ctrl CTRL_RESET = '{
        pos: 3'd0, phase: PH_START, minus: 1'b0, base: BASE_RESET,
        ovf: 1'b0, digit_seen: 1'b0, invalid: 1'b0, qchar: 8'd0
    };

    function automatic logic [5:0] clamp_base(input logic [5:0] b);
        logic [5:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    // Digit value of a character; letters of either case count 10 to 35.
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.valid = 1'b1;
        d.value = 6'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = 6'(c - CH_ZERO);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d.value = 6'(c - CH_LOWER_A) + 6'd10;
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d.value = 6'(c - CH_UPPER_A) + 6'd10;
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ----- design/prefixed_number_token_parser_top.sv -----
// Top level of the prefixed number token parser: handshakes, registers and config port.
// Depends on pntp_pkg, pntp_step, pntp_result and the assertion macro header.
//
// The parser takes a word one character per item on the slave stream, tlast marking the
// final character, and returns one result item per word on the master stream: tuser says
// whether the word is a number and tdata carries its value in two's complement. A word may
// open with + or -, then a base prefix (& or # decimal, b or % binary, h, $ or 0x hex, the
// hex forms rejected when the default base is 33 or more), then digits in the active base
// with letters of either case. An unsigned word may instead be a quote, one character and
// an optional closing quote, giving that byte. Digits build up in an ACCUM_WIDTH-bit
// accumulator; on overflow the word is rejected, or, with the saturate register set, takes
// the signed maximum or minimum cut to RESULT_WIDTH bits. One character is accepted every
// clock cycle with no bubbles between words, unless a final character waits for the output
// register. Each character passes an input register and then the next-state logic, whose
// longest path is the accumulator multiply-add (ACCUM_WIDTH by 6 bits plus the digit)
// followed by the sign negation of the result; a word's result is loaded into the output
// register when its last character leaves the input register, or later while an earlier
// result still waits there. The output register frees for the next word as soon as
// its item is taken, and intermediate characters keep flowing while a result waits.
// Configuration writes are taken at any time, one per cycle, and are meant to be made while
// no word is in flight.
module prefixed_number_token_parser_top #(
    parameter int RESULT_WIDTH = pntp_pkg::RESULT_WIDTH_DEF,
    parameter int ACCUM_WIDTH  = pntp_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Character stream.
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,    // [7:0] char_code
    input  logic                                 i_s_tlast,    // last_char
    // Result stream.
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((RESULT_WIDTH+7)/8)*8-1:0]    o_m_tdata,    // value, zero padded
    output logic [0:0]                           o_m_tuser,    // [0] is_number
    // Configuration writes.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pntp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [pntp_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    localparam int OUT_TDATA_W = ((RESULT_WIDTH + 7) / 8) * 8;

    // Configuration registers.
    logic [5:0] r_dflt_base;
    logic       r_sat;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // Word state.
    pntp_pkg::t_ctrl        r_st;
    pntp_pkg::t_ctrl        n_st;
    logic [ACCUM_WIDTH-1:0] r_acc;
    logic [ACCUM_WIDTH-1:0] n_acc;

    // Output register.
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [RESULT_WIDTH-1:0] r_out_value;
    logic                    n_ok;
    logic [RESULT_WIDTH-1:0] n_value;

    logic out_free;
    logic step_fire;

    // A character that ends a word needs the output register; any other one always moves.
    assign out_free   = !r_out_valid || i_m_tready;
    assign step_fire  = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || step_fire;

    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_value);
    assign o_m_tuser  = r_out_ok;

    pntp_step #(.AW(ACCUM_WIDTH)) u_step (
        .i_char      (r_in_char),
        .i_st        (r_st),
        .i_acc       (r_acc),
        .i_dflt_base (r_dflt_base),
        .o_st        (n_st),
        .o_acc       (n_acc)
    );

    pntp_result #(.RW(RESULT_WIDTH), .AW(ACCUM_WIDTH)) u_result (
        .i_st    (n_st),
        .i_acc   (n_acc),
        .i_sat   (r_sat),
        .o_ok    (n_ok),
        .o_value (n_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt_base <= pntp_pkg::BASE_RESET;
            r_sat       <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pntp_pkg::CFG_DEFAULT_BASE: r_dflt_base <= i_cfg_data;
                pntp_pkg::CFG_OVERFLOW_SAT: r_sat       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // The word state returns to its start values after each final character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= pntp_pkg::CTRL_RESET;
            r_acc <= '0;
        end else if (step_fire) begin
            if (r_in_last) begin
                r_st  <= pntp_pkg::CTRL_RESET;
                r_acc <= '0;
            end else begin
                r_st  <= n_st;
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && r_in_last) begin
            r_out_ok    <= n_ok;
            r_out_value <= n_value;
        end
    end

`include "prefixed_number_token_parser_top_macros.svh"

    `PNTP_ASSERT(a_last_gives_result,
        step_fire && r_in_last |=> r_out_valid,
        "final character gave no result")
    `PNTP_ASSERT(a_result_from_last,
        $rose(r_out_valid) |-> $past(step_fire && r_in_last),
        "result without final character")
    `PNTP_NEVER(a_reject_is_zero,
        r_out_valid && !r_out_ok && r_out_value != '0,
        "rejected word carries a value")
    `PNTP_ASSERT(a_word_restarts,
        step_fire && r_in_last |=> r_st.phase == pntp_pkg::PH_START && r_st.pos == 3'd0,
        "word state not cleared")

endmodule

// ----- design/pntp_mac.sv -----
// Accumulator multiply-add: acc * base + digit, with a flag when the result leaves AW bits.
// Depends on nothing beyond its parameter.
module pntp_mac #(
    parameter int AW = 64
) (
    input  logic [AW-1:0] i_acc,
    input  logic [5:0]    i_base,
    input  logic [5:0]    i_digit,
    output logic [AW-1:0] o_sum,
    output logic          o_ovf
);

    logic [AW+5:0] prod;
    logic [AW+5:0] sum;

    // The product of an AW-bit value and a base of at most 36 fits in AW+6 bits.
    assign prod  = {6'd0, i_acc} * {{AW{1'b0}}, i_base};
    assign sum   = prod + {{AW{1'b0}}, i_digit};
    assign o_sum = sum[AW-1:0];
    assign o_ovf = |sum[AW+5:AW];

endmodule

// ----- design/pntp_step.sv -----
// Next-state logic for one character of a word: grammar, base prefixes and digit accumulation.
// Depends on pntp_pkg and pntp_mac.
module pntp_step #(
    parameter int AW = 64
) (
    input  logic [7:0]           i_char,
    input  pntp_pkg::t_ctrl      i_st,
    input  logic [AW-1:0]        i_acc,
    input  logic [5:0]           i_dflt_base,
    output pntp_pkg::t_ctrl      o_st,
    output logic [AW-1:0]        o_acc
);

    logic [5:0]       clamped;
    logic [5:0]       base_eff;
    pntp_pkg::t_digit dig;
    logic [AW-1:0]    mac_sum;
    logic             mac_ovf;
    logic             take;
    logic             zero_after;
    logic             dig_bad;

    assign clamped  = pntp_pkg::clamp_base(i_dflt_base);
    // The base is latched from the register on the first character of a word.
    assign base_eff = (i_st.phase == pntp_pkg::PH_START) ? clamped : i_st.base;
    assign dig      = pntp_pkg::digit_of(i_char);
    assign dig_bad  = !dig.valid || (dig.value >= base_eff);

    pntp_mac #(.AW(AW)) u_mac (
        .i_acc   (i_acc),
        .i_base  (base_eff),
        .i_digit (dig.value),
        .o_sum   (mac_sum),
        .o_ovf   (mac_ovf)
    );

    always_comb begin
        logic prefix;
        o_st       = i_st;
        o_acc      = i_acc;
        o_st.base  = base_eff;
        take       = 1'b0;
        zero_after = 1'b0;
        prefix     = 1'b0;

        case (i_st.phase)
            pntp_pkg::PH_START: begin
                if (i_char == pntp_pkg::CH_MINUS) begin
                    o_st.minus = 1'b1;
                    o_st.phase = pntp_pkg::PH_PREFIX;
                end else if (i_char == pntp_pkg::CH_PLUS) begin
                    o_st.phase = pntp_pkg::PH_PREFIX;
                end else begin
                    prefix = 1'b1;
                end
            end
            pntp_pkg::PH_PREFIX: begin
                prefix = 1'b1;
            end
            pntp_pkg::PH_ZERO: begin
                if (i_char == pntp_pkg::CH_LOWER_X) begin
                    o_st.phase = pntp_pkg::PH_DIGITS;
                    if (clamped >= pntp_pkg::BASE_HEX_LIMIT) begin
                        o_st.invalid = 1'b1;
                    end else begin
                        o_st.base       = pntp_pkg::BASE_HEX;
                        o_acc           = '0;
                        o_st.digit_seen = 1'b0;
                    end
                end else begin
                    take = 1'b1;
                end
            end
            pntp_pkg::PH_DIGITS: begin
                take = 1'b1;
            end
            pntp_pkg::PH_QCHAR: begin
                o_st.qchar = i_char;
                o_st.phase = pntp_pkg::PH_QCLOSE;
            end
            pntp_pkg::PH_QCLOSE: begin
                if (i_char == pntp_pkg::CH_QUOTE) begin
                    o_st.phase = pntp_pkg::PH_QDONE;
                end else begin
                    o_st.invalid = 1'b1;
                end
            end
            default: begin
                o_st.invalid = 1'b1;
            end
        endcase

        // The character right after an optional sign may select the base.
        if (prefix) begin
            o_st.phase = pntp_pkg::PH_DIGITS;
            case (i_char)
                pntp_pkg::CH_AMP, pntp_pkg::CH_HASH: begin
                    o_st.base = pntp_pkg::BASE_DEC;
                end
                pntp_pkg::CH_LOWER_B, pntp_pkg::CH_PERCENT: begin
                    o_st.base = pntp_pkg::BASE_BIN;
                end
                pntp_pkg::CH_LOWER_H, pntp_pkg::CH_DOLLAR: begin
                    if (clamped >= pntp_pkg::BASE_HEX_LIMIT) begin
                        o_st.invalid = 1'b1;
                    end else begin
                        o_st.base = pntp_pkg::BASE_HEX;
                    end
                end
                pntp_pkg::CH_QUOTE: begin
                    if (i_st.minus || i_st.pos != 3'd0) begin
                        o_st.invalid = 1'b1;
                    end else begin
                        o_st.phase = pntp_pkg::PH_QCHAR;
                    end
                end
                pntp_pkg::CH_ZERO: begin
                    take       = 1'b1;
                    zero_after = 1'b1;
                end
                default: begin
                    take = 1'b1;
                end
            endcase
        end

        // Digit accumulation stops growing once the accumulator has overflowed.
        if (take) begin
            o_st.phase = zero_after ? pntp_pkg::PH_ZERO : pntp_pkg::PH_DIGITS;
            if (dig_bad) begin
                o_st.invalid = 1'b1;
            end else begin
                o_st.digit_seen = 1'b1;
                if (!i_st.ovf) begin
                    if (mac_ovf) begin
                        o_st.ovf = 1'b1;
                    end else begin
                        o_acc = mac_sum;
                    end
                end
            end
        end

        if (i_st.pos != pntp_pkg::POS_MAX) begin
            o_st.pos = i_st.pos + 3'd1;
        end
    end

endmodule

// ----- design/pntp_result.sv -----
// Forms the result of a finished word: number flag and signed, possibly saturated value.
// Depends on pntp_pkg.
module pntp_result #(
    parameter int RW = 32,
    parameter int AW = 64
) (
    input  pntp_pkg::t_ctrl i_st,
    input  logic [AW-1:0]   i_acc,
    input  logic            i_sat,
    output logic            o_ok,
    output logic [RW-1:0]   o_value
);

    logic [pntp_pkg::MAX_WIDTH-1:0] acc_ext;
    logic [pntp_pkg::MAX_WIDTH-1:0] top;
    logic [pntp_pkg::MAX_WIDTH-1:0] val;

    assign acc_ext = pntp_pkg::MAX_WIDTH'(i_acc);
    assign top     = pntp_pkg::MAX_WIDTH'(1) << (AW - 1);

    always_comb begin
        o_ok = 1'b0;
        val  = '0;
        if (!i_st.invalid) begin
            if (i_st.phase == pntp_pkg::PH_QCLOSE || i_st.phase == pntp_pkg::PH_QDONE) begin
                o_ok = 1'b1;
                val  = pntp_pkg::MAX_WIDTH'(i_st.qchar);
            end else if ((i_st.phase == pntp_pkg::PH_DIGITS
                          || i_st.phase == pntp_pkg::PH_ZERO) && i_st.digit_seen) begin
                if (!i_st.ovf) begin
                    o_ok = 1'b1;
                    val  = i_st.minus ? (pntp_pkg::MAX_WIDTH'(0) - acc_ext) : acc_ext;
                end else if (i_sat) begin
                    o_ok = 1'b1;
                    val  = i_st.minus ? top : (top - pntp_pkg::MAX_WIDTH'(1));
                end
            end
        end
        o_value = val[RW-1:0];
    end

endmodule
